### sv/rtsch_pkg.sv
// ----------------------------------------------------------------------------
// rtsch_pkg
// Shared types and constants of the retransmit table scheduler.
// ----------------------------------------------------------------------------
package rtsch_pkg;

  localparam int unsigned TableDepthDef = 16;

  // field widths
  localparam int unsigned KeyW   = 24;
  localparam int unsigned FlagsW = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 9;
  localparam int unsigned MaxW   = 8;
  localparam int unsigned IntvW  = 16;

  // stream payload widths
  localparam int unsigned InDataW  = 112;
  localparam int unsigned InUserW  = 1;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned OutUserW = 2;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegMaxResends     = 1'b0;
  localparam logic [CfgIdxW-1:0] RegResendInterval = 1'b1;

  localparam logic [MaxW-1:0]  MaxResendsRst     = 8'd3;
  localparam logic [IntvW-1:0] ResendIntervalRst = 16'd10;

  // item opcodes
  localparam logic OpStore = 1'b0;
  localparam logic OpPoll  = 1'b1;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [FlagsW-1:0] flags;
    logic [ByteW-1:0]  pressure;
    logic [ByteW-1:0]  temperature;
    logic [ByteW-1:0]  check;
    logic [TimeW-1:0]  due;
    logic [CountW-1:0] count;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_MISS,
    ST_SH_RD,
    ST_SH_WR,
    ST_DONE
  } state_e;

endpackage

### sv/rtsch_ram.sv
// ----------------------------------------------------------------------------
// rtsch_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rtsch_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/retransmit_table_scheduler.sv
// ----------------------------------------------------------------------------
// retransmit_table_scheduler
// Ordered packet table with store and poll-for-retransmission operations.
// ----------------------------------------------------------------------------
// Input items arrive on s_axis (tuser = opcode: store or poll, tdata = time
// and packet). Each item gives exactly one result on m_axis (tuser = ok and
// retired flags, tdata = frame being resent, zero when nothing is given).
// Registers max_resends and resend_interval are written on the cfg channel,
// which is always ready; write them only while no item is in flight.
// The table lives in one RAM. A sequencer walks the used entries in order,
// reading each entry and then comparing it, through a single shared
// subtract/compare unit (key match for a store, due-time test for a poll).
// A retired entry makes each later entry close up by a read and a write.
// Scanned and shifted entries together never exceed the table. s_axis_tready
// is high only while idle, one item at a time. A finished result sits in an
// output register, so the next item is taken while it waits; if the receiver
// still stalls when the following result is done, the sequencer holds. Reset
// empties the table and restores the register defaults; no clearing pass is
// needed.
// ----------------------------------------------------------------------------
module retransmit_table_scheduler #(
  parameter int unsigned TABLE_DEPTH = rtsch_pkg::TableDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // now, packet_flags, packet_id, packet_pressure, packet_temperature, packet_check
  input  logic [rtsch_pkg::InDataW-1:0]     s_axis_tdata_i,
  // opcode
  input  logic [rtsch_pkg::InUserW-1:0]     s_axis_tuser_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // frame_flags, frame_id, frame_pressure, frame_temperature, frame_check
  output logic [rtsch_pkg::OutDataW-1:0]    m_axis_tdata_o,
  // ok, retired
  output logic [rtsch_pkg::OutUserW-1:0]    m_axis_tuser_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rtsch_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rtsch_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  rtsch_pkg::state_e state_q, state_d;

  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] used_q, used_d;
  logic          op_q, op_d;
  logic [rtsch_pkg::TimeW-1:0] now_q, now_d;
  rtsch_pkg::entry_t pkt_q, pkt_d;

  logic                res_ok_q, res_ok_d;
  logic                res_ret_q, res_ret_d;
  rtsch_pkg::entry_t   res_q, res_d;

  logic                                out_valid_q, out_valid_d;
  logic [rtsch_pkg::OutDataW-1:0]      out_data_q, out_data_d;
  logic [rtsch_pkg::OutUserW-1:0]      out_user_q, out_user_d;

  logic [rtsch_pkg::MaxW-1:0]  max_q, max_d;
  logic [rtsch_pkg::IntvW-1:0] intv_q, intv_d;

  // table RAM
  logic                         ram_we;
  logic [IW-1:0]                ram_waddr, ram_raddr;
  rtsch_pkg::entry_t            ram_wdata, ram_rdata;

  rtsch_ram #(
    .Width ($bits(rtsch_pkg::entry_t)),
    .Depth (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // input unpack
  logic [rtsch_pkg::TimeW-1:0] in_now;
  logic [rtsch_pkg::TimeW:0]   due_sum;
  logic [rtsch_pkg::TimeW-1:0] due_sat;
  logic                        in_accept, out_free;

  assign in_now    = s_axis_tdata_i[31:0];
  assign due_sum   = {1'b0, in_now} + {17'd0, intv_q};
  assign due_sat   = due_sum[rtsch_pkg::TimeW] ? '1 : due_sum[rtsch_pkg::TimeW-1:0];
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;

  // shared compare unit: equality for key match, borrow for due < now
  logic [rtsch_pkg::TimeW-1:0] cmp_a, cmp_b;
  logic [rtsch_pkg::TimeW:0]   cmp_diff;
  logic                        cmp_eq, cmp_lt, hit;

  always_comb begin
    if (op_q == rtsch_pkg::OpStore) begin
      cmp_a = {8'd0, ram_rdata.key};
      cmp_b = {8'd0, pkt_q.key};
    end else begin
      cmp_a = ram_rdata.due;
      cmp_b = now_q;
    end
  end

  assign cmp_diff = {1'b0, cmp_a} - {1'b0, cmp_b};
  assign cmp_eq   = (cmp_diff[rtsch_pkg::TimeW-1:0] == '0);
  assign cmp_lt   = cmp_diff[rtsch_pkg::TimeW];
  assign hit      = (op_q == rtsch_pkg::OpStore) ? cmp_eq : cmp_lt;

  logic [rtsch_pkg::CountW-1:0] cnt_new;
  logic                         retire, last, more_after, more_shift;

  assign cnt_new    = ram_rdata.count + 9'd1;
  assign retire     = cnt_new > {1'b0, max_q};
  assign last       = ({1'b0, idx_q} + (CW+1)'(1)) == {1'b0, used_q};
  assign more_after = ({1'b0, idx_q} + (CW+1)'(1)) < {1'b0, used_q};
  assign more_shift = ({1'b0, idx_q} + (CW+1)'(2)) < {1'b0, used_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rtsch_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = (used_q == '0) ? rtsch_pkg::ST_MISS : rtsch_pkg::ST_RD;
        end
      end
      rtsch_pkg::ST_RD: state_d = rtsch_pkg::ST_CHK;
      rtsch_pkg::ST_CHK: begin
        if (hit) begin
          if (op_q == rtsch_pkg::OpPoll && retire && more_after) begin
            state_d = rtsch_pkg::ST_SH_RD;
          end else begin
            state_d = rtsch_pkg::ST_DONE;
          end
        end else if (last) begin
          state_d = rtsch_pkg::ST_MISS;
        end else begin
          state_d = rtsch_pkg::ST_RD;
        end
      end
      rtsch_pkg::ST_MISS:  state_d = rtsch_pkg::ST_DONE;
      rtsch_pkg::ST_SH_RD: state_d = rtsch_pkg::ST_SH_WR;
      rtsch_pkg::ST_SH_WR: begin
        state_d = more_shift ? rtsch_pkg::ST_SH_RD : rtsch_pkg::ST_DONE;
      end
      rtsch_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = rtsch_pkg::ST_IDLE;
        end
      end
      default: state_d = rtsch_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_d       = idx_q;
    used_d      = used_q;
    op_d        = op_q;
    now_d       = now_q;
    pkt_d       = pkt_q;
    res_ok_d    = res_ok_q;
    res_ret_d   = res_ret_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[IW-1:0];
    ram_wdata   = pkt_q;
    ram_raddr   = idx_q[IW-1:0];

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      rtsch_pkg::ST_IDLE: begin
        if (in_accept) begin
          op_d              = s_axis_tuser_i[0];
          now_d             = in_now;
          pkt_d.flags       = s_axis_tdata_i[63:32];
          pkt_d.key         = s_axis_tdata_i[87:64];
          pkt_d.pressure    = s_axis_tdata_i[95:88];
          pkt_d.temperature = s_axis_tdata_i[103:96];
          pkt_d.check       = s_axis_tdata_i[111:104];
          pkt_d.due         = due_sat;
          pkt_d.count       = '0;
          idx_d             = '0;
          res_ok_d          = 1'b0;
          res_ret_d         = 1'b0;
          res_d             = '0;
        end
      end
      rtsch_pkg::ST_RD: ;
      rtsch_pkg::ST_CHK: begin
        if (hit) begin
          res_ok_d = 1'b1;
          if (op_q == rtsch_pkg::OpStore) begin
            ram_we = 1'b1;
          end else begin
            res_d       = ram_rdata;
            res_ret_d   = retire;
            if (!retire) begin
              ram_we          = 1'b1;
              ram_wdata       = ram_rdata;
              ram_wdata.due   = pkt_q.due;
              ram_wdata.count = cnt_new;
            end else if (!more_after) begin
              used_d = used_q - CW'(1);
            end
          end
        end else if (!last) begin
          idx_d = idx_q + CW'(1);
        end
      end
      rtsch_pkg::ST_MISS: begin
        // append a new id when there is room
        if (op_q == rtsch_pkg::OpStore && used_q < DepthC) begin
          ram_we    = 1'b1;
          ram_waddr = used_q[IW-1:0];
          used_d    = used_q + CW'(1);
          res_ok_d  = 1'b1;
        end
      end
      rtsch_pkg::ST_SH_RD: begin
        ram_raddr = IW'(idx_q + CW'(1));
      end
      rtsch_pkg::ST_SH_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        idx_d     = idx_q + CW'(1);
        if (!more_shift) begin
          used_d = used_q - CW'(1);
        end
      end
      rtsch_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {res_q.check, res_q.temperature, res_q.pressure,
                         res_q.key, res_q.flags};
          out_user_d  = {res_ret_q, res_ok_q};
        end
      end
      default: ;
    endcase
  end

  // configuration writes
  always_comb begin
    max_d  = max_q;
    intv_d = intv_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rtsch_pkg::RegMaxResends:     max_d  = cfg_data_i[rtsch_pkg::MaxW-1:0];
        rtsch_pkg::RegResendInterval: intv_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtsch_pkg::ST_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      max_q       <= rtsch_pkg::MaxResendsRst;
      intv_q      <= rtsch_pkg::ResendIntervalRst;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      max_q       <= max_d;
      intv_q      <= intv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    op_q       <= op_d;
    now_q      <= now_d;
    pkt_q      <= pkt_d;
    res_ok_q   <= res_ok_d;
    res_ret_q  <= res_ret_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign s_axis_tready_o = (state_q == rtsch_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign cfg_ready_o     = 1'b1;

endmodule

### sv/rtsch_checker.sv
// ----------------------------------------------------------------------------
// rtsch_checker
// Port-level checks of the retransmit table scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rtsch_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic [rtsch_pkg::OutDataW-1:0]    m_axis_tdata_o,
  input logic [rtsch_pkg::OutUserW-1:0]    m_axis_tuser_o,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i
);

  // one item at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted again while an item is in flight");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // retired only for a frame that was given
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tuser_o[0])
    else $error("retired flag without ok");

  // a failed item carries an all-zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == '0 && !m_axis_tuser_o[1])
    else $error("failed result carries nonzero fields");

endmodule

bind retransmit_table_scheduler rtsch_checker u_rtsch_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);
